[design/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants for the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // pool size and register reset value
    localparam int unsigned P_MAX_BLOCKS      = 1024;
    localparam int unsigned P_CNT_W           = 11;
    localparam int unsigned P_IDX_W           = 10;
    localparam logic [P_CNT_W-1:0] P_BLOCK_COUNT_RST = 11'd1024;

    // stream data widths, padded to whole bytes
    localparam int unsigned P_S_TDATA_W = 16;
    localparam int unsigned P_M_TDATA_W = 24;

    // operation codes carried on s_tuser
    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic sweep_wr;  // write one init link, advance sweep pointer
        logic accept;    // item taken this cycle, load result and update list
        logic pop;       // load head from the link read last cycle
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic sweep_last;  // sweep pointer on the last entry
        logic pool_empty;  // no block counted free
        logic out_busy;    // result register holds an item that is not taken
    } t_dp_sts;

endpackage

[design/fbpa_ctrl.sv]
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Controller: clearing pass, item acceptance and the head pop sequence.
// ----------------------------------------------------------------------------
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_valid,
    input  t_op     i_op,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ready = !i_sts.out_busy;
                if (i_valid && !i_sts.out_busy) begin
                    o_cmd.accept = 1'b1;
                    // a granted allocate still has to follow the link
                    if (i_op == OP_ALLOC && !i_sts.pool_empty) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_POP: begin
                o_cmd.pop = 1'b1;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
        // a register write restarts the list from scratch
        if (i_cfg_we) begin
            n_state = ST_CLEAR;
        end
    end

endmodule

[design/fbpa_dp.sv]
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: link memory, head pointer, free count and result register.
// ----------------------------------------------------------------------------
module fbpa_dp
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = P_MAX_BLOCKS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [P_CNT_W-1:0]   i_cfg_data,
    input  t_op                  i_op,
    input  logic [P_IDX_W-1:0]   i_free_index,
    input  logic                 i_out_ready,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output logic                 o_out_valid,
    output logic                 o_granted,
    output logic [P_IDX_W-1:0]   o_block_index,
    output logic                 o_rejected,
    output logic [P_CNT_W-1:0]   o_blocks_free
);

    localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

    logic [IW-1:0]      r_links [MAX_BLOCKS];
    logic [IW-1:0]      r_rdata;
    logic [P_CNT_W-1:0] r_block_count;
    logic [IW-1:0]      r_sweep;
    logic [IW-1:0]      r_head;
    logic [CW-1:0]      r_free;
    logic               r_out_valid;
    logic               r_granted;
    logic [IW-1:0]      r_block;
    logic               r_rejected;
    logic [CW-1:0]      r_out_free;

    logic [CW-1:0]      w_eff;
    logic               w_sweep_last;
    logic               w_is_free;
    logic               w_reject;
    logic               w_push;
    logic               w_grant;
    logic [IW-1:0]      w_idx;
    logic [CW-1:0]      n_free;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [IW-1:0]      w_wdata;

    // block count clamped to the pool size
    assign w_eff = (32'(r_block_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS) : CW'(r_block_count);

    assign w_sweep_last = (r_sweep == IW'(MAX_BLOCKS - 1));
    assign w_is_free    = (i_op == OP_FREE);
    assign w_reject     = (32'(i_free_index) >= 32'(w_eff));
    assign w_push       = i_cmd.accept && w_is_free && !w_reject;
    assign w_grant      = (r_free != '0);
    assign w_idx        = IW'(i_free_index);

    // free count after the item
    always_comb begin
        n_free = r_free;
        if (w_is_free) begin
            if (!w_reject && (r_free < w_eff)) begin
                n_free = r_free + CW'(1);
            end
        end else if (w_grant) begin
            n_free = r_free - CW'(1);
        end
    end

    // link memory write port: init sweep or push
    assign w_we    = i_cmd.sweep_wr || w_push;
    assign w_waddr = i_cmd.sweep_wr ? r_sweep : w_idx;
    assign w_wdata = i_cmd.sweep_wr ? (w_sweep_last ? '0 : r_sweep + IW'(1)) : r_head;

    // link memory, read port follows the head
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_links[w_waddr] <= w_wdata;
        end
        r_rdata <= r_links[r_head];
    end

    // register, sweep pointer, head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= P_BLOCK_COUNT_RST;
            r_sweep       <= '0;
            r_head        <= '0;
            r_free        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_block_count <= i_cfg_data;
                r_sweep       <= '0;
            end else if (i_cmd.sweep_wr) begin
                r_sweep <= w_sweep_last ? '0 : r_sweep + IW'(1);
            end
            if (i_cmd.sweep_wr) begin
                r_head <= '0;
                r_free <= w_eff;
            end else if (i_cmd.pop) begin
                r_head <= r_rdata;
            end else if (i_cmd.accept) begin
                r_free <= n_free;
                if (w_push) begin
                    r_head <= w_idx;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_granted  <= !w_is_free && w_grant;
            r_block    <= (!w_is_free && w_grant) ? r_head : '0;
            r_rejected <= w_is_free && w_reject;
            r_out_free <= n_free;
        end
    end

    assign o_sts.sweep_last = w_sweep_last;
    assign o_sts.pool_empty = !w_grant;
    assign o_sts.out_busy   = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_granted     = r_granted;
    assign o_block_index = P_IDX_W'(r_block);
    assign o_rejected    = r_rejected;
    assign o_blocks_free = P_CNT_W'(r_out_free);

endmodule

[design/fixed_block_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// LIFO free-list allocator of equal blocks with a block count register.
// ----------------------------------------------------------------------------
// Input stream s_*: s_tuser selects allocate (0) or free (1), s_tdata carries
// the index of the block being returned. Output stream m_*: one result per
// item with the grant, the allocated index, the reject flag for an out of
// range free, and the number of free blocks after the item.
// After a free the controller stays in ST_IDLE; a granted allocate first
// passes through ST_POP: the pop has to read the head's link from the
// synchronous link memory before the next item can use the new head. The
// result appears on m_tvalid the cycle after the item is taken.
// The result sits in an output register; a new item is taken while it waits
// as long as it is consumed in the same cycle. A stalled receiver holds the
// result and keeps s_tready low until it is taken.
// After reset, and after each write of block_count, a clearing pass over
// all MAX_BLOCKS link entries rebuilds the ascending free list; s_tready
// stays low during that pass. block_count writes are taken at any time.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS = P_MAX_BLOCKS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // block count register
    input  logic                   i_cfg_we,
    input  logic [P_CNT_W-1:0]     i_cfg_data,
    // item input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [P_S_TDATA_W-1:0] s_tdata,   // [9:0] free_index, [15:10] zero
    input  logic                   s_tuser,   // [0] operation
    // result output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [P_M_TDATA_W-1:0] m_tdata    // [0] granted, [10:1] block_index,
                                              // [11] rejected, [22:12] blocks_free,
                                              // [23] zero
);

    t_dp_cmd              w_cmd;
    t_dp_sts              w_sts;
    t_op                  w_op;
    logic                 w_granted;
    logic [P_IDX_W-1:0]   w_block_index;
    logic                 w_rejected;
    logic [P_CNT_W-1:0]   w_blocks_free;

    assign w_op = t_op'(s_tuser);

    // controller
    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_valid (s_tvalid),
        .i_op    (w_op),
        .i_sts   (w_sts),
        .o_ready (s_tready),
        .o_cmd   (w_cmd)
    );

    // datapath
    fbpa_dp #(
        .MAX_BLOCKS(MAX_BLOCKS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_op         (w_op),
        .i_free_index (s_tdata[P_IDX_W-1:0]),
        .i_out_ready  (m_tready),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_out_valid  (m_tvalid),
        .o_granted    (w_granted),
        .o_block_index(w_block_index),
        .o_rejected   (w_rejected),
        .o_blocks_free(w_blocks_free)
    );

    // pack result fields from the lowest bit up
    assign m_tdata = {1'b0, w_blocks_free, w_rejected, w_block_index, w_granted};

endmodule

[sim/tb_fixed_block_pool_allocator.sv]
// ----------------------------------------------------------------------------
// tb_fixed_block_pool_allocator
// Self-checking testbench for the fixed block pool allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free items into the stream input and checks every
// result against a mirror of the free list kept in the testbench. The block
// count register is rewritten between phases while the block is idle. This
// covers the empty and oversized pools, out of range frees and double frees.
// Both stream sides idle at random, the receiver holds off long enough to
// fill the block, and the sender pauses once until every result is back.
// ----------------------------------------------------------------------------
module tb_fixed_block_pool_allocator
    import fbpa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned PHASE_ITEMS    = 55;

    // one result item as the block reports it
    typedef struct {
        logic                granted;
        logic [P_IDX_W-1:0]  block_index;
        logic                rejected;
        logic [P_CNT_W-1:0]  blocks_free;
    } t_alloc_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_cfg_we   = 1'b0;
    logic [P_CNT_W-1:0]     i_cfg_data = '0;
    logic                   s_tvalid   = 1'b0;
    logic                   s_tready;
    logic [P_S_TDATA_W-1:0] s_tdata    = '0;  // [9:0] free_index, [15:10] zero
    logic                   s_tuser    = 1'b0; // [0] operation
    logic                   m_tvalid;
    logic                   m_tready   = 1'b0;
    logic [P_M_TDATA_W-1:0] m_tdata;   // [0] granted, [10:1] block_index,
                                       // [11] rejected, [22:12] blocks_free,
                                       // [23] zero

    // mirror of the free list
    logic [P_IDX_W-1:0]     link_mirror [P_MAX_BLOCKS];
    logic [P_CNT_W-1:0]     head_mirror;
    logic [P_CNT_W-1:0]     free_mirror;
    logic [P_CNT_W-1:0]     block_count_mirror;

    t_alloc_result          pending_results [$];
    logic [P_IDX_W-1:0]     held_blocks [$];

    int                     mismatch_count = 0;
    int                     result_count   = 0;
    int                     idle_cycles    = 0;
    bit                     tx_steady      = 1'b0;
    bit                     rx_steady      = 1'b0;
    bit                     rx_hold_req    = 1'b0;
    int                     alloc_pct      = 45;

    fixed_block_pool_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // clock
    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // block count in effect, oversized values clip to the pool size
    function automatic logic [P_CNT_W-1:0] usable_blocks();
        return (block_count_mirror > P_MAX_BLOCKS) ? P_CNT_W'(P_MAX_BLOCKS)
                                                   : block_count_mirror;
    endfunction

    // ascending list, as after reset or a count write
    function automatic void rebuild_pool();
        for (int i = 0; i < P_MAX_BLOCKS; i++)
            link_mirror[i] = (i + 1 < P_MAX_BLOCKS) ? P_IDX_W'(i + 1) : '0;
        head_mirror = '0;
        free_mirror = usable_blocks();
        held_blocks.delete();
    endfunction

    // most gaps short, a few long
    function automatic int pick_gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("result %0d: %s is %0d, expected %0d", result_count, what, got, want);
        mismatch_count++;
    endtask

    // apply one accepted item to the mirror and queue its result
    task automatic apply_pool_op(input t_op op, input logic [P_IDX_W-1:0] idx);
        t_alloc_result      res;
        logic [P_IDX_W-1:0] top;
        logic [P_CNT_W-1:0] usable;
        usable          = usable_blocks();
        res.granted     = 1'b0;
        res.block_index = '0;
        res.rejected    = 1'b0;
        top = (head_mirror < P_MAX_BLOCKS) ? head_mirror[P_IDX_W-1:0] : '0;
        if (op == OP_ALLOC) begin
            if (free_mirror != 0) begin
                res.granted     = 1'b1;
                res.block_index = top;
                head_mirror     = {1'b0, link_mirror[top]};
                free_mirror     = free_mirror - 1'b1;
                held_blocks.push_back(top);
            end
        end else if ({1'b0, idx} >= usable) begin
            res.rejected = 1'b1;
        end else begin
            link_mirror[idx] = top;
            head_mirror      = {1'b0, idx};
            // double frees push again but the count saturates
            if (free_mirror < usable)
                free_mirror = free_mirror + 1'b1;
            foreach (held_blocks[i]) begin
                if (held_blocks[i] == idx) begin
                    held_blocks.delete(i);
                    break;
                end
            end
        end
        res.blocks_free = free_mirror;
        pending_results.push_back(res);
    endtask

    // offer one item, hold it until taken
    task automatic send_item(input t_op op, input logic [P_IDX_W-1:0] idx);
        int gap;
        gap = (tx_steady || $urandom_range(0, 99) < 55) ? 0 : pick_gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(P_S_TDATA_W - P_IDX_W){1'b0}}, idx};
        @(posedge i_clk);
        while (s_tready !== 1'b1) @(posedge i_clk);
        apply_pool_op(op, idx);
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_results_done();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_block_count(input logic [P_CNT_W-1:0] value);
        wait_results_done();
        // let a pending pop finish before the list is rebuilt
        repeat (4) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        block_count_mirror = value;
        rebuild_pool();
    endtask

    // mostly frees of held blocks and allocates, some stray frees
    task automatic send_mixed_op();
        int                 r;
        logic [P_CNT_W-1:0] usable;
        usable = usable_blocks();
        r = $urandom_range(0, 99);
        if (r < alloc_pct || (r < 85 && held_blocks.size() == 0))
            send_item(OP_ALLOC, P_IDX_W'($urandom_range(0, P_MAX_BLOCKS - 1)));
        else if (r < 85)
            send_item(OP_FREE, held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
        else if (r < 93 || usable >= P_MAX_BLOCKS)
            send_item(OP_FREE, P_IDX_W'($urandom_range(0, P_MAX_BLOCKS - 1)));
        else
            send_item(OP_FREE, P_IDX_W'($urandom_range(0, usable)));
    endtask

    // reset count, empty pool, single block, oversized count
    task automatic test_directed_cases();
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_ALLOC, 10'd1023);
        send_item(OP_FREE,  10'd0);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_FREE,  10'd1023);
        send_item(OP_FREE,  10'd1023);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_ALLOC, 10'd0);
        write_block_count(11'd0);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_FREE,  10'd0);
        send_item(OP_FREE,  10'd1023);
        write_block_count(11'd1);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_FREE,  10'd1);
        send_item(OP_FREE,  10'd0);
        send_item(OP_FREE,  10'd0);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_ALLOC, 10'd0);
        write_block_count(11'd2047);
        send_item(OP_ALLOC, 10'd0);
        send_item(OP_FREE,  10'd1023);
        send_item(OP_FREE,  10'h2AA);
        send_item(OP_FREE,  10'h155);
        write_block_count(11'd1024);
        send_item(OP_ALLOC, 10'd0);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_stall_fill();
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        repeat (40) send_mixed_op();
        tx_steady   = 1'b0;
    endtask

    // sender pauses until every result is back, then resumes
    task automatic test_sender_pause();
        repeat (20) send_mixed_op();
        wait_results_done();
        repeat (20) send_mixed_op();
    endtask

    // random traffic over a series of pool sizes
    task automatic test_random_traffic();
        logic [P_CNT_W-1:0] sizes [10];
        sizes = '{11'd8, 11'd1, 11'd3, 11'd64, 11'd1024, 11'd2047, 11'd16,
                  11'd1100, 11'd0, 11'd5};
        sizes[6] = P_CNT_W'($urandom_range(2, 40));
        foreach (sizes[p]) begin
            write_block_count(sizes[p]);
            alloc_pct = $urandom_range(35, 60);
            tx_steady = (p == 2);
            rx_steady = (p == 2 || p == 4);
            repeat (PHASE_ITEMS) send_mixed_op();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // receiver side ready pattern
    initial begin : rx_drive
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_steady || !i_rst_n) begin
                m_tready <= i_rst_n;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = pick_gap_len();
            end
        end
    end

    // check each result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_alloc_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("result %0d arrived with none expected", result_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.granted)
                    report_mismatch("granted", int'(m_tdata[0]), int'(want.granted));
                if (m_tdata[10:1] !== want.block_index)
                    report_mismatch("block_index", int'(m_tdata[10:1]),
                                    int'(want.block_index));
                if (m_tdata[11] !== want.rejected)
                    report_mismatch("rejected", int'(m_tdata[11]), int'(want.rejected));
                if (m_tdata[22:12] !== want.blocks_free)
                    report_mismatch("blocks_free", int'(m_tdata[22:12]),
                                    int'(want.blocks_free));
            end
            result_count++;
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // test sequence
    initial begin
        block_count_mirror = P_BLOCK_COUNT_RST;
        rebuild_pool();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_output_stall_fill();
        test_sender_pause();
        test_random_traffic();

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
